// File: hw/rtl/so3_pkg.sv
// Shared types, constants and arithmetic helpers for the attitude controller.
`timescale 1ns / 1ps
package so3_pkg;

	localparam int CORDIC_ITERS     = 16;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int CORDIC_GAIN      = 652032874;
	localparam int ANG_PI           = 205887;
	localparam int ANG_HALF_PI      = 102944;
	localparam int MIX_QUARTER      = 16384;
	localparam int MIX_EIGHTH       = 8192;
	localparam int MIX_ROOT5        = 7327;

	typedef enum logic [2:0] {
		REG_ROLL_KP  = 3'd0,
		REG_PITCH_KP = 3'd1,
		REG_YAW_KP   = 3'd2,
		REG_ROLL_KD  = 3'd3,
		REG_PITCH_KD = 3'd4,
		REG_YAW_KD   = 3'd5,
		REG_SET_ROLL = 3'd6,
		REG_SET_PITCH = 3'd7
	} so3_reg_t;

	typedef struct packed {
		logic signed [15:0] set_yaw;
		logic signed [15:0] surge;
		logic signed [15:0] sway;
		logic signed [15:0] heave;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} so3_in_t;

	typedef struct packed {
		logic signed [15:0] motor_1;
		logic signed [15:0] motor_2;
		logic signed [15:0] motor_3;
		logic signed [15:0] motor_4;
		logic signed [15:0] motor_5;
		logic signed [15:0] motor_6;
	} so3_out_t;

	typedef struct packed {
		logic [15:0]        roll_kp;
		logic [15:0]        pitch_kp;
		logic [15:0]        yaw_kp;
		logic [15:0]        roll_kd;
		logic [15:0]        pitch_kd;
		logic [15:0]        yaw_kd;
		logic signed [15:0] set_roll;
		logic signed [15:0] set_pitch;
	} so3_cfg_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [19:0] z;
		logic               flip;
	} so3_cl_t;

	typedef struct packed {
		logic signed [17:0] cy;
		logic signed [17:0] sy;
		logic signed [17:0] cp;
		logic signed [17:0] sp;
		logic signed [17:0] cr;
		logic signed [17:0] sr;
	} so3_trig_t;

	typedef struct packed {
		logic signed [35:0] ex;
		logic signed [35:0] ey;
		logic signed [35:0] ez;
	} so3_err_t;

	function automatic logic signed [19:0] atan_lut(logic [3:0] i);
		logic signed [19:0] r;
		case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30385;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] rnd(logic signed [63:0] v, int unsigned s);
		logic signed [63:0] h;
		h = 64'sd1 <<< (s - 1);
		return (v + h) >>> s;
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/so3_cordic.sv
// Pipelined CORDIC for the three half-angle sine and cosine pairs.
`timescale 1ns / 1ps
module so3_cordic
	import so3_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  so3_in_t            in_data,
	input  logic signed [15:0] set_roll,
	input  logic signed [15:0] set_pitch,
	output logic               out_valid,
	output so3_in_t            out_data,
	output so3_trig_t          out_trig
);

	localparam int NST = CORDIC_ITERS / CORDIC_PER_STAGE;

	so3_cl_t lane_sn [NST][3];
	so3_in_t side_sn [NST];
	logic    vld_sn  [NST];
	logic signed [17:0] c_sf [3];
	logic signed [17:0] s_sf [3];
	logic signed [15:0] ang [3];

	function automatic so3_cl_t reduce(logic signed [15:0] a);
		so3_cl_t v;
		logic signed [19:0] z;
		z = 20'(a) <<< 2;
		v.flip = 1'b0;
		if (z > 20'(ANG_HALF_PI)) begin
			z = z - 20'(ANG_PI);
			v.flip = 1'b1;
		end else if (z < -20'(ANG_HALF_PI)) begin
			z = z + 20'(ANG_PI);
			v.flip = 1'b1;
		end
		v.z = z;
		v.x = 33'(CORDIC_GAIN);
		v.y = '0;
		return v;
	endfunction

	function automatic so3_cl_t cstep(so3_cl_t v, logic [3:0] i);
		so3_cl_t r;
		logic signed [32:0] xs;
		logic signed [32:0] ys;
		xs = v.x >>> i;
		ys = v.y >>> i;
		r = v;
		if (!v.z[19]) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - atan_lut(i);
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + atan_lut(i);
		end
		return r;
	endfunction

	function automatic so3_cl_t cstage(so3_cl_t v, int base);
		so3_cl_t r;
		r = v;
		for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
			r = cstep(r, 4'(base + k));
		end
		return r;
	endfunction

	function automatic logic signed [17:0] c_round(logic signed [32:0] v);
		logic signed [32:0] r;
		r = (v + 33'sd16384) >>> 15;
		return r[17:0];
	endfunction

	assign ang[0] = in_data.set_yaw;
	assign ang[1] = set_pitch;
	assign ang[2] = set_roll;

	always_ff @(posedge clk) begin
		if (en) begin
			side_sn[0] <= in_data;
			for (int l = 0; l < 3; l++) begin
				lane_sn[0][l] <= cstage(reduce(ang[l]), 0);
			end
			for (int st = 1; st < NST; st++) begin
				side_sn[st] <= side_sn[st-1];
				for (int l = 0; l < 3; l++) begin
					lane_sn[st][l] <= cstage(lane_sn[st-1][l], st * CORDIC_PER_STAGE);
				end
			end
			out_data <= side_sn[NST-1];
			for (int l = 0; l < 3; l++) begin
				c_sf[l] <= lane_sn[NST-1][l].flip ? -c_round(lane_sn[NST-1][l].x)
				                                  : c_round(lane_sn[NST-1][l].x);
				s_sf[l] <= lane_sn[NST-1][l].flip ? -c_round(lane_sn[NST-1][l].y)
				                                  : c_round(lane_sn[NST-1][l].y);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < NST; st++) begin
				vld_sn[st] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			vld_sn[0] <= in_valid;
			for (int st = 1; st < NST; st++) begin
				vld_sn[st] <= vld_sn[st-1];
			end
			out_valid <= vld_sn[NST-1];
		end
	end

	assign out_trig.cy = c_sf[0];
	assign out_trig.sy = s_sf[0];
	assign out_trig.cp = c_sf[1];
	assign out_trig.sp = s_sf[1];
	assign out_trig.cr = c_sf[2];
	assign out_trig.sr = s_sf[2];

endmodule

// File: hw/rtl/so3_err.sv
// Desired quaternion, both rotation matrices and the attitude error vector.
`timescale 1ns / 1ps
module so3_err
	import so3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  so3_in_t   in_data,
	input  so3_trig_t in_trig,
	output logic      out_valid,
	output so3_in_t   out_data,
	output so3_err_t  out_err
);

	typedef logic signed [23:0] so3_rot_t [9];

	logic signed [19:0] cycp_s1, sysp_s1, sycp_s1, cysp_s1;
	logic signed [17:0] cr_s1, sr_s1;
	logic signed [19:0] qw_s2, qx_s2, qy_s2, qz_s2;
	so3_rot_t rd_s3, rm_s3;
	logic signed [47:0] pos_s4 [3][3];
	logic signed [47:0] neg_s4 [3][3];
	so3_in_t d_s1, d_s2, d_s3, d_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	function automatic logic signed [19:0] mulr(logic signed [19:0] a, logic signed [19:0] b);
		logic signed [63:0] r;
		r = rnd(64'(a) * 64'(b), 15);
		return r[19:0];
	endfunction

	function automatic logic signed [23:0] rterm(logic signed [63:0] v);
		logic signed [63:0] r;
		r = rnd(64'sd2 * v, 15);
		return r[23:0];
	endfunction

	function automatic so3_rot_t to_rot(logic signed [19:0] w, logic signed [19:0] x,
	                                     logic signed [19:0] y, logic signed [19:0] z);
		so3_rot_t r;
		logic signed [63:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
		xx = 64'(x) * 64'(x);
		yy = 64'(y) * 64'(y);
		zz = 64'(z) * 64'(z);
		xy = 64'(x) * 64'(y);
		xz = 64'(x) * 64'(z);
		yz = 64'(y) * 64'(z);
		xw = 64'(x) * 64'(w);
		yw = 64'(y) * 64'(w);
		zw = 64'(z) * 64'(w);
		r[0] = 24'sd32768 - rterm(yy + zz);
		r[1] = rterm(xy - zw);
		r[2] = rterm(xz + yw);
		r[3] = rterm(xy + zw);
		r[4] = 24'sd32768 - rterm(xx + zz);
		r[5] = rterm(yz - xw);
		r[6] = rterm(xz - yw);
		r[7] = rterm(yz + xw);
		r[8] = 24'sd32768 - rterm(xx + yy);
		return r;
	endfunction

	function automatic logic signed [35:0] err_axis(logic signed [47:0] p [3],
	                                                logic signed [47:0] n [3]);
		logic signed [63:0] acc;
		acc = 64'(p[0]) + 64'(p[1]) + 64'(p[2]) - 64'(n[0]) - 64'(n[1]) - 64'(n[2]);
		acc = rnd(acc, 16);
		return acc[35:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cycp_s1 <= mulr(20'(in_trig.cy), 20'(in_trig.cp));
			sysp_s1 <= mulr(20'(in_trig.sy), 20'(in_trig.sp));
			sycp_s1 <= mulr(20'(in_trig.sy), 20'(in_trig.cp));
			cysp_s1 <= mulr(20'(in_trig.cy), 20'(in_trig.sp));
			cr_s1   <= in_trig.cr;
			sr_s1   <= in_trig.sr;
			d_s1    <= in_data;

			qw_s2 <= mulr(cycp_s1, 20'(cr_s1)) + mulr(sysp_s1, 20'(sr_s1));
			qx_s2 <= mulr(cycp_s1, 20'(sr_s1)) - mulr(sysp_s1, 20'(cr_s1));
			qy_s2 <= mulr(sycp_s1, 20'(sr_s1)) + mulr(cysp_s1, 20'(cr_s1));
			qz_s2 <= mulr(sycp_s1, 20'(cr_s1)) - mulr(cysp_s1, 20'(sr_s1));
			d_s2  <= d_s1;

			rd_s3 <= to_rot(qw_s2, qx_s2, qy_s2, qz_s2);
			rm_s3 <= to_rot(20'(d_s2.quat_w), 20'(d_s2.quat_x),
			                20'(d_s2.quat_y), 20'(d_s2.quat_z));
			d_s3  <= d_s2;

			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					pos_s4[a][k] <= 48'(rd_s3[3*k + (a+2)%3]) * 48'(rm_s3[3*k + (a+1)%3]);
					neg_s4[a][k] <= 48'(rd_s3[3*k + (a+1)%3]) * 48'(rm_s3[3*k + (a+2)%3]);
				end
			end
			d_s4 <= d_s3;

			out_err.ex <= err_axis(pos_s4[0], neg_s4[0]);
			out_err.ey <= err_axis(pos_s4[1], neg_s4[1]);
			out_err.ez <= err_axis(pos_s4[2], neg_s4[2]);
			out_data   <= d_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

endmodule

// File: hw/rtl/so3_mix.sv
// PD torque law and thruster mixer with output saturation.
`timescale 1ns / 1ps
module so3_mix
	import so3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  so3_cfg_t cfg,
	input  logic     in_valid,
	input  so3_in_t  in_data,
	input  so3_err_t in_err,
	output logic     out_valid,
	output so3_out_t out_data
);

	logic [15:0]        kp [3];
	logic [15:0]        kd [3];
	logic signed [35:0] ev [3];
	logic signed [15:0] rt [3];
	logic signed [55:0] pk_s1 [3];
	logic signed [55:0] pd_s1 [3];
	logic signed [57:0] t_s2 [3];
	logic signed [63:0] n_s3 [4];
	logic signed [15:0] tx_s1, ty_s1, tz_s1, tx_s2, ty_s2, tz_s2, tx_s3, ty_s3;
	logic v_s1, v_s2, v_s3;
	logic signed [63:0] g;

	assign kp[0] = cfg.roll_kp;
	assign kp[1] = cfg.pitch_kp;
	assign kp[2] = cfg.yaw_kp;
	assign kd[0] = cfg.roll_kd;
	assign kd[1] = cfg.pitch_kd;
	assign kd[2] = cfg.yaw_kd;
	assign ev[0] = in_err.ex;
	assign ev[1] = in_err.ey;
	assign ev[2] = in_err.ez;
	assign rt[0] = in_data.rate_x;
	assign rt[1] = in_data.rate_y;
	assign rt[2] = in_data.rate_z;
	assign g     = 64'(tz_s2) * 64'sd512;

	function automatic logic signed [55:0] gmul(logic [15:0] k, logic signed [63:0] v);
		logic signed [63:0] r;
		r = 64'($signed({1'b0, k})) * v;
		return r[55:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pk_s1[k] <= gmul(kp[k], 64'(ev[k]));
				pd_s1[k] <= gmul(kd[k], 64'(rt[k]) * 64'sd256 - 64'(ev[k]));
			end
			tx_s1 <= in_data.surge;
			ty_s1 <= in_data.sway;
			tz_s1 <= in_data.heave;

			for (int k = 0; k < 3; k++) begin
				t_s2[k] <= -58'(pk_s1[k]) - 58'(pd_s1[k]);
			end
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;
			tz_s2 <= tz_s1;

			n_s3[0] <= 64'(MIX_QUARTER) * (g + 64'(t_s2[0])) + 64'(MIX_EIGHTH) * 64'(t_s2[1])
			         + 64'(MIX_ROOT5) * 64'(t_s2[2]);
			n_s3[1] <= 64'(MIX_QUARTER) * (g - 64'(t_s2[0])) + 64'(MIX_EIGHTH) * 64'(t_s2[1])
			         - 64'(MIX_ROOT5) * 64'(t_s2[2]);
			n_s3[2] <= 64'(MIX_QUARTER) * (g - 64'(t_s2[0])) - 64'(MIX_EIGHTH) * 64'(t_s2[1])
			         + 64'(MIX_ROOT5) * 64'(t_s2[2]);
			n_s3[3] <= 64'(MIX_QUARTER) * (g + 64'(t_s2[0])) - 64'(MIX_EIGHTH) * 64'(t_s2[1])
			         - 64'(MIX_ROOT5) * 64'(t_s2[2]);
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;

			out_data.motor_1 <= sat16(rnd(n_s3[0], 25));
			out_data.motor_2 <= sat16(rnd(n_s3[1], 25));
			out_data.motor_3 <= sat16(rnd(n_s3[2], 25));
			out_data.motor_4 <= sat16(rnd(n_s3[3], 25));
			out_data.motor_5 <= sat16((64'(tx_s3) - 64'(ty_s3)) >>> 1);
			out_data.motor_6 <= sat16((64'(tx_s3) + 64'(ty_s3)) >>> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

endmodule

// File: hw/rtl/so3_attitude_controller_mixer_core.sv
// Top level of the attitude controller: configuration registers and pipeline.
// Throughput: one request per cycle unless stalled; CORDIC stages do two iterations each.
// The whole pipeline holds while a result waits at the output under stall.
// Reset clears all valid bits and loads the default gains and zero roll and pitch.
`timescale 1ns / 1ps
module so3_attitude_controller_mixer_core
	import so3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  so3_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output so3_out_t    out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	so3_cfg_t  cfg_q;
	logic      en;
	logic      cv, ev;
	so3_in_t   cd, ed;
	so3_trig_t trig;
	so3_err_t  err;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_kp   <= 16'd1280;
			cfg_q.pitch_kp  <= 16'd1280;
			cfg_q.yaw_kp    <= 16'd768;
			cfg_q.roll_kd   <= 16'd1280;
			cfg_q.pitch_kd  <= 16'd1280;
			cfg_q.yaw_kd    <= 16'd768;
			cfg_q.set_roll  <= '0;
			cfg_q.set_pitch <= '0;
		end else if (cfg_we) begin
			case (so3_reg_t'(cfg_index))
				REG_ROLL_KP:   cfg_q.roll_kp   <= cfg_data;
				REG_PITCH_KP:  cfg_q.pitch_kp  <= cfg_data;
				REG_YAW_KP:    cfg_q.yaw_kp    <= cfg_data;
				REG_ROLL_KD:   cfg_q.roll_kd   <= cfg_data;
				REG_PITCH_KD:  cfg_q.pitch_kd  <= cfg_data;
				REG_YAW_KD:    cfg_q.yaw_kd    <= cfg_data;
				REG_SET_ROLL:  cfg_q.set_roll  <= cfg_data;
				REG_SET_PITCH: cfg_q.set_pitch <= cfg_data;
				default:       cfg_q.roll_kp   <= cfg_q.roll_kp;
			endcase
		end
	end

	so3_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.set_roll  (cfg_q.set_roll),
		.set_pitch (cfg_q.set_pitch),
		.out_valid (cv),
		.out_data  (cd),
		.out_trig  (trig)
	);

	so3_err u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv),
		.in_data   (cd),
		.in_trig   (trig),
		.out_valid (ev),
		.out_data  (ed),
		.out_err   (err)
	);

	so3_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (ev),
		.in_data   (ed),
		.in_err    (err),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_held_result_stays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result lost or changed");

	a_roll_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_SET_ROLL |=> cfg_q.set_roll == $past(cfg_data))
		else $error("roll setpoint write not taken");

	a_gain_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_YAW_KD |=> cfg_q.yaw_kd == $past(cfg_data))
		else $error("yaw rate gain write not taken");

endmodule

// File: test/so3_attitude_controller_mixer_core_test.sv
// Self-checking testbench for the attitude controller and thruster mixer core.
`timescale 1ns / 1ps
module so3_attitude_controller_mixer_core_test;
	import so3_pkg::*;

	localparam int LATENCY = 18;
	localparam int N_RANDOM = 730;

	typedef logic signed [63:0] s64_t;

	typedef struct {
		so3_in_t  req;
		logic     has_motors;
		so3_out_t motors;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	so3_in_t in_data;
	logic out_valid;
	logic out_stall;
	so3_out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] gain_p [3];
	logic [15:0] gain_d [3];
	logic signed [15:0] roll_sp;
	logic signed [15:0] pitch_sp;

	so3_out_t motors_due [$];
	int errors;
	bit hold_out;
	bit long_hold_req;

	so3_attitude_controller_mixer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("status: fail");
		$finish;
	end

	function automatic s64_t shr_floor(s64_t v, int s);
		return v >>> s;
	endfunction

	function automatic s64_t shr_round(s64_t v, int s);
		return (v + (s64_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] clamp16(s64_t v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic void half_angle_trig(input s64_t ang, output s64_t c, output s64_t s);
		s64_t z, x, y, xs, ys;
		s64_t atan_steps [16];
		bit flip;
		atan_steps = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		z = ang * 4;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 102944) begin
			z -= 205887;
			flip = 1;
		end else if (z < -102944) begin
			z += 205887;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_steps[i];
			end else begin
				x += ys; y -= xs; z += atan_steps[i];
			end
		end
		c = shr_round(x, 15);
		s = shr_round(y, 15);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic void quat_to_matrix(input s64_t w, input s64_t x, input s64_t y,
			input s64_t z, output s64_t m [9]);
		m[0] = 32768 - shr_round(2 * (y * y + z * z), 15);
		m[1] = shr_round(2 * (x * y - z * w), 15);
		m[2] = shr_round(2 * (x * z + y * w), 15);
		m[3] = shr_round(2 * (x * y + z * w), 15);
		m[4] = 32768 - shr_round(2 * (x * x + z * z), 15);
		m[5] = shr_round(2 * (y * z - x * w), 15);
		m[6] = shr_round(2 * (x * z - y * w), 15);
		m[7] = shr_round(2 * (y * z + x * w), 15);
		m[8] = 32768 - shr_round(2 * (x * x + y * y), 15);
	endfunction

	function automatic s64_t rdt_r(s64_t rd [9], s64_t r [9], int i, int j);
		s64_t acc;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			acc += rd[3 * k + i] * r[3 * k + j];
		end
		return acc;
	endfunction

	function automatic so3_out_t mix_motors(so3_in_t req);
		s64_t cy, sy, cp, sp, cr, sr, cycp, sysp, sycp, cysp, qw, qx, qy, qz, g;
		s64_t rd [9];
		s64_t rm [9];
		s64_t e [3];
		s64_t t [3];
		s64_t n [4];
		s64_t rates [3];
		so3_out_t o;
		half_angle_trig(s64_t'(req.set_yaw), cy, sy);
		half_angle_trig(s64_t'(pitch_sp), cp, sp);
		half_angle_trig(s64_t'(roll_sp), cr, sr);
		cycp = shr_round(cy * cp, 15);
		sysp = shr_round(sy * sp, 15);
		sycp = shr_round(sy * cp, 15);
		cysp = shr_round(cy * sp, 15);
		qw = shr_round(cycp * cr, 15) + shr_round(sysp * sr, 15);
		qx = shr_round(cycp * sr, 15) - shr_round(sysp * cr, 15);
		qy = shr_round(sycp * sr, 15) + shr_round(cysp * cr, 15);
		qz = shr_round(sycp * cr, 15) - shr_round(cysp * sr, 15);
		quat_to_matrix(qw, qx, qy, qz, rd);
		quat_to_matrix(s64_t'(req.quat_w), s64_t'(req.quat_x), s64_t'(req.quat_y),
			s64_t'(req.quat_z), rm);
		e[0] = shr_round(rdt_r(rd, rm, 2, 1) - rdt_r(rd, rm, 1, 2), 16);
		e[1] = shr_round(rdt_r(rd, rm, 0, 2) - rdt_r(rd, rm, 2, 0), 16);
		e[2] = shr_round(rdt_r(rd, rm, 1, 0) - rdt_r(rd, rm, 0, 1), 16);
		rates[0] = s64_t'(req.rate_x);
		rates[1] = s64_t'(req.rate_y);
		rates[2] = s64_t'(req.rate_z);
		for (int k = 0; k < 3; k++) begin
			t[k] = -(s64_t'({1'b0, gain_p[k]}) * e[k])
				- s64_t'({1'b0, gain_d[k]}) * (rates[k] * 256 - e[k]);
		end
		g = s64_t'(req.heave) * 512;
		n[0] = MIX_QUARTER * (g + t[0]) + MIX_EIGHTH * t[1] + MIX_ROOT5 * t[2];
		n[1] = MIX_QUARTER * (g - t[0]) + MIX_EIGHTH * t[1] - MIX_ROOT5 * t[2];
		n[2] = MIX_QUARTER * (g - t[0]) - MIX_EIGHTH * t[1] + MIX_ROOT5 * t[2];
		n[3] = MIX_QUARTER * (g + t[0]) - MIX_EIGHTH * t[1] - MIX_ROOT5 * t[2];
		o.motor_1 = clamp16(shr_round(n[0], 25));
		o.motor_2 = clamp16(shr_round(n[1], 25));
		o.motor_3 = clamp16(shr_round(n[2], 25));
		o.motor_4 = clamp16(shr_round(n[3], 25));
		o.motor_5 = clamp16(shr_floor(s64_t'(req.surge) - s64_t'(req.sway), 1));
		o.motor_6 = clamp16(shr_floor(s64_t'(req.surge) + s64_t'(req.sway), 1));
		return o;
	endfunction

	task automatic write_reg(input so3_reg_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ROLL_KP:   gain_p[0] = val;
			REG_PITCH_KP:  gain_p[1] = val;
			REG_YAW_KP:    gain_p[2] = val;
			REG_ROLL_KD:   gain_d[0] = val;
			REG_PITCH_KD:  gain_d[1] = val;
			REG_YAW_KD:    gain_d[2] = val;
			REG_SET_ROLL:  roll_sp = val;
			REG_SET_PITCH: pitch_sp = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] v [8]);
		for (int i = 0; i < 8; i++) begin
			write_reg(so3_reg_t'(i), v[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (motors_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_request(input so3_in_t req, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		motors_due.push_back(mix_motors(req));
	endtask

	function automatic so3_in_t random_request();
		so3_in_t r;
		logic [191:0] raw;
		int unsigned mode;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[175:0];
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// shrink quaternion components and rates by random shifts
			r.quat_w = $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 2);
			r.quat_x = $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(1, 4);
			r.quat_y = $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(1, 4);
			r.quat_z = $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(1, 4);
			r.rate_x = $signed(r.rate_x) >>> $urandom_range(0, 10);
			r.rate_y = $signed(r.rate_y) >>> $urandom_range(0, 10);
			r.rate_z = $signed(r.rate_z) >>> $urandom_range(0, 10);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (long_hold_req) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_out;
		end
	end

	initial begin
		int n;
		hold_out = 0;
		forever begin
			@(posedge clk);
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			hold_out = 1;
			repeat (n) @(posedge clk);
			hold_out = 0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (motors_due.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_data);
				errors++;
			end else begin
				so3_out_t exp_m;
				exp_m = motors_due.pop_front();
				if (exp_m.motor_1 !== out_data.motor_1)
					$display("%0t motor_1 exp %0d got %0d", $time, exp_m.motor_1, out_data.motor_1);
				if (exp_m.motor_2 !== out_data.motor_2)
					$display("%0t motor_2 exp %0d got %0d", $time, exp_m.motor_2, out_data.motor_2);
				if (exp_m.motor_3 !== out_data.motor_3)
					$display("%0t motor_3 exp %0d got %0d", $time, exp_m.motor_3, out_data.motor_3);
				if (exp_m.motor_4 !== out_data.motor_4)
					$display("%0t motor_4 exp %0d got %0d", $time, exp_m.motor_4, out_data.motor_4);
				if (exp_m.motor_5 !== out_data.motor_5)
					$display("%0t motor_5 exp %0d got %0d", $time, exp_m.motor_5, out_data.motor_5);
				if (exp_m.motor_6 !== out_data.motor_6)
					$display("%0t motor_6 exp %0d got %0d", $time, exp_m.motor_6, out_data.motor_6);
				if (exp_m !== out_data) begin
					errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		logic [15:0] setting [8];
		logic signed [15:0] yaw_pts [8];
		int waited;
		errors = 0;
		long_hold_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gain_p = '{16'd1280, 16'd1280, 16'd768};
		gain_d = '{16'd1280, 16'd1280, 16'd768};
		roll_sp = 0;
		pitch_sp = 0;
		yaw_pts = '{16'sh7fff, 16'sh8000, 16'sd25736, -16'sd25736, 16'sd12868, 16'sd12869,
			-16'sd12869, 16'sd1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity attitude, zero yaw and rates: all motors zero after reset
		row.req = '0; row.req.quat_w = 16'sh7fff;
		row.has_motors = 1; row.motors = '0; rows.push_back(row);
		row.req = '0; row.req.quat_w = 16'sh7fff; row.req.surge = 16'sh7fff;
		row.req.sway = 16'sh8000;
		row.motors = '0; row.motors.motor_5 = 16'sh7fff; row.motors.motor_6 = -16'sd1;
		rows.push_back(row);
		row.req = '0; row.req.quat_w = 16'sh7fff; row.req.surge = 16'sh8000;
		row.req.sway = 16'sh8000;
		row.motors = '0; row.motors.motor_5 = 16'sd0; row.motors.motor_6 = 16'sh8000;
		rows.push_back(row);
		row.has_motors = 0;
		foreach (yaw_pts[i]) begin
			row.req = '0; row.req.quat_w = 16'sh7fff;
			row.req.set_yaw = yaw_pts[i];
			rows.push_back(row);
		end
		row.req = {11{16'sh7fff}}; rows.push_back(row);
		row.req = {11{16'sh8000}}; rows.push_back(row);
		row.req = {11{16'shffff}}; rows.push_back(row);
		row.req = {11{16'sh5555}}; rows.push_back(row);
		row.req = {11{16'shaaaa}}; rows.push_back(row);
		row.req = '0; row.req.heave = 16'sh7fff; rows.push_back(row);
		row.req = '0; row.req.quat_x = 16'sh7fff; row.req.rate_x = 16'sh7fff; rows.push_back(row);
		row.req = '0; row.req.quat_y = 16'sh8000; row.req.rate_y = 16'sh8000; rows.push_back(row);
		row.req = '0; row.req.quat_z = 16'sh7fff; row.req.rate_z = 16'sh8000; rows.push_back(row);

		foreach (rows[i]) begin
			if (rows[i].has_motors && mix_motors(rows[i].req) !== rows[i].motors) begin
				$display("%0t table row %0d exp %h got %h", $time, i, rows[i].motors,
					mix_motors(rows[i].req));
				errors++;
			end
			send_request(rows[i].req, $urandom_range(0, 2));
		end
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'sh8000, 16'sh7fff};
				1: setting = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
					16'sh7fff, 16'sh8000};
				2: setting = '{16'd1280, 16'd1280, 16'd768, 16'd1280, 16'd1280, 16'd768,
					16'd0, 16'd0};
				default: for (int i = 0; i < 8; i++) setting[i] = 16'($urandom_range(0, 65535));
			endcase
			write_all(setting);
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				if (phase == 3 && i == 20) begin
					fork
						begin
							long_hold_req = 1;
							repeat (150) @(posedge clk);
							long_hold_req = 0;
						end
					join_none
				end
				if (phase == 4 && i == 40) begin
					waited = 0;
					in_valid <= 1'b0;
					while (motors_due.size() != 0) @(posedge clk);
				end
				send_request(random_request(),
					($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13) * (i % 2));
			end
			drain();
		end

		waited = 0;
		while (motors_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0 && motors_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
